// File: rtl/sirc_ir_pulse_decoder_defines.svh
// Assertion macros shared by the SIRC decoder RTL.
`ifndef SIRC_IR_PULSE_DECODER_DEFINES_SVH
`define SIRC_IR_PULSE_DECODER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define SIRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SIRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define SIRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/sirc_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the SIRC decoder modules.
package sirc_pkg;

    localparam int ADDR_W = 5;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_VARIANT     = 3'd0,
        REG_HDR_MARK    = 3'd1,
        REG_BIT_SPACE   = 3'd2,
        REG_ONE_MARK    = 3'd3,
        REG_ZERO_MARK   = 3'd4,
        REG_TRAILER_MIN = 3'd5
    } sirc_reg_t;

    localparam logic [1:0] VAR_12 = 2'd0;
    localparam logic [1:0] VAR_15 = 2'd1;
    localparam logic [1:0] VAR_20 = 2'd2;

    localparam logic [1:0] MODE_MARK    = 2'd0;
    localparam logic [1:0] MODE_SPACE   = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [12:0] DEV_MASK_12 = 13'h001F;
    localparam logic [12:0] DEV_MASK_15 = 13'h00FF;
    localparam logic [12:0] DEV_MASK_20 = 13'h1FFF;

    localparam int WIN_LO_PCT = 65;
    localparam int WIN_HI_PCT = 135;

    localparam int HDR_MARK_RESET   = 2400;
    localparam int BIT_SPACE_RESET  = 600;
    localparam int ONE_MARK_RESET   = 1200;
    localparam int ZERO_MARK_RESET  = 600;
    localparam int TRAILER_RESET    = 10000;

    // acceptance window for one nominal pulse time
    typedef struct packed {
        logic [15:0] lo;
        logic [16:0] hi;
    } sirc_win_t;

    typedef struct packed {
        logic [1:0]  variant;
        sirc_win_t   hdr_mark;
        sirc_win_t   bit_space;
        sirc_win_t   one_mark;
        sirc_win_t   zero_mark;
        logic [23:0] trailer_min;
    } sirc_cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  command;
        logic [12:0] device;
        logic [19:0] raw_value;
        logic [1:0]  variant_out;
    } sirc_result_t;

endpackage

// File: rtl/sirc_window.sv
`timescale 1ns / 1ps
// Window bounds floor(T*65/100) and floor(T*135/100) for a nominal time.
module sirc_window
    import sirc_pkg::*;
(
    input  logic [15:0] nominal,
    output sirc_win_t   win
);

    // ceil(2^30/100); exact for dividends below 2^30/76
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int          RECIP_SH  = 30;

    logic [23:0] scaled_lo;
    logic [23:0] scaled_hi;
    logic [47:0] prod_lo;
    logic [47:0] prod_hi;

    // x*65 = x*64 + x ; x*135 = x*128 + x*8 - x
    assign scaled_lo = 24'({nominal, 6'b0}) + 24'(nominal);
    assign scaled_hi = 24'({nominal, 7'b0}) + 24'({nominal, 3'b0}) - 24'(nominal);

    assign prod_lo = 48'(scaled_lo) * 48'(RECIP_100);
    assign prod_hi = 48'(scaled_hi) * 48'(RECIP_100);

    assign win.lo = prod_lo[RECIP_SH +: 16];
    assign win.hi = prod_hi[RECIP_SH +: 17];

endmodule

// File: rtl/sirc_cfg.sv
`timescale 1ns / 1ps
// APB register file; window bounds are worked out as each time is written.
module sirc_cfg
    import sirc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sirc_cfg_t         cfg
);

    localparam logic [15:0] HDR_LO  = 16'((HDR_MARK_RESET * WIN_LO_PCT) / 100);
    localparam logic [16:0] HDR_HI  = 17'((HDR_MARK_RESET * WIN_HI_PCT) / 100);
    localparam logic [15:0] SPC_LO  = 16'((BIT_SPACE_RESET * WIN_LO_PCT) / 100);
    localparam logic [16:0] SPC_HI  = 17'((BIT_SPACE_RESET * WIN_HI_PCT) / 100);
    localparam logic [15:0] ONE_LO  = 16'((ONE_MARK_RESET * WIN_LO_PCT) / 100);
    localparam logic [16:0] ONE_HI  = 17'((ONE_MARK_RESET * WIN_HI_PCT) / 100);
    localparam logic [15:0] ZERO_LO = 16'((ZERO_MARK_RESET * WIN_LO_PCT) / 100);
    localparam logic [16:0] ZERO_HI = 17'((ZERO_MARK_RESET * WIN_HI_PCT) / 100);

    logic [1:0]  variant_reg;
    logic [15:0] hdr_mark_reg;
    logic [15:0] bit_space_reg;
    logic [15:0] one_mark_reg;
    logic [15:0] zero_mark_reg;
    logic [23:0] trailer_reg;
    sirc_win_t   hdr_win_reg;
    sirc_win_t   spc_win_reg;
    sirc_win_t   one_win_reg;
    sirc_win_t   zero_win_reg;

    sirc_win_t   wr_win;
    sirc_reg_t   reg_sel;
    logic        wr_en;

    sirc_window u_window (
        .nominal (pwdata[15:0]),
        .win     (wr_win)
    );

    assign pready  = 1'b1;
    assign reg_sel = sirc_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= VAR_12;
            hdr_mark_reg  <= 16'(HDR_MARK_RESET);
            bit_space_reg <= 16'(BIT_SPACE_RESET);
            one_mark_reg  <= 16'(ONE_MARK_RESET);
            zero_mark_reg <= 16'(ZERO_MARK_RESET);
            trailer_reg   <= 24'(TRAILER_RESET);
            hdr_win_reg   <= '{lo: HDR_LO, hi: HDR_HI};
            spc_win_reg   <= '{lo: SPC_LO, hi: SPC_HI};
            one_win_reg   <= '{lo: ONE_LO, hi: ONE_HI};
            zero_win_reg  <= '{lo: ZERO_LO, hi: ZERO_HI};
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_VARIANT:
                begin
                    variant_reg <= pwdata[1:0];
                end
                REG_HDR_MARK:
                begin
                    hdr_mark_reg <= pwdata[15:0];
                    hdr_win_reg  <= wr_win;
                end
                REG_BIT_SPACE:
                begin
                    bit_space_reg <= pwdata[15:0];
                    spc_win_reg   <= wr_win;
                end
                REG_ONE_MARK:
                begin
                    one_mark_reg <= pwdata[15:0];
                    one_win_reg  <= wr_win;
                end
                REG_ZERO_MARK:
                begin
                    zero_mark_reg <= pwdata[15:0];
                    zero_win_reg  <= wr_win;
                end
                REG_TRAILER_MIN:
                begin
                    trailer_reg <= pwdata[23:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_VARIANT:     prdata = 32'(variant_reg);
            REG_HDR_MARK:    prdata = 32'(hdr_mark_reg);
            REG_BIT_SPACE:   prdata = 32'(bit_space_reg);
            REG_ONE_MARK:    prdata = 32'(one_mark_reg);
            REG_ZERO_MARK:   prdata = 32'(zero_mark_reg);
            REG_TRAILER_MIN: prdata = 32'(trailer_reg);
            default:         prdata = '0;
        endcase
    end

    // code 3 decodes as the 20-bit frame
    assign cfg.variant     = (variant_reg >= VAR_20) ? VAR_20 : variant_reg;
    assign cfg.hdr_mark    = hdr_win_reg;
    assign cfg.bit_space   = spc_win_reg;
    assign cfg.one_mark    = one_win_reg;
    assign cfg.zero_mark   = zero_win_reg;
    assign cfg.trailer_min = trailer_reg;

endmodule

// File: rtl/sirc_core.sv
`timescale 1ns / 1ps
// Frame decode state machine with its result register.
`include "sirc_ir_pulse_decoder_defines.svh"
module sirc_core
    import sirc_pkg::*;
#(
    parameter int DURATION_BITS  = 24,
    parameter int MAX_FRAME_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sirc_cfg_t                cfg,
    input  logic                     load_en,
    input  logic [1:0]               mode,
    input  logic [DURATION_BITS-1:0] duration,
    output sirc_result_t             result
);

    localparam int LW = $clog2(MAX_FRAME_BITS + 1);
    localparam int SW = MAX_FRAME_BITS;
    localparam int CW = (DURATION_BITS > 17) ? DURATION_BITS : 17;
    localparam int TW = (DURATION_BITS > 24) ? DURATION_BITS : 24;

    localparam logic [LW-1:0] LEN_12 = LW'((MAX_FRAME_BITS < 12) ? MAX_FRAME_BITS : 12);
    localparam logic [LW-1:0] LEN_15 = LW'((MAX_FRAME_BITS < 15) ? MAX_FRAME_BITS : 15);
    localparam logic [LW-1:0] LEN_20 = LW'((MAX_FRAME_BITS < 20) ? MAX_FRAME_BITS : 20);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_HDR_SPACE = 2'd1,
        PH_BIT_MARK  = 2'd2,
        PH_BIT_SPACE = 2'd3
    } phase_t;

    phase_t        phase_reg,   phase_next;
    logic [LW-1:0] count_reg,   count_next;
    logic [SW-1:0] shift_reg,   shift_next;
    logic          pending_reg, pending_next;
    sirc_result_t  result_reg,  result_next;

    logic [LW-1:0] frame_len;
    logic [LW:0]   len_ext;
    logic [LW:0]   count_inc;
    logic [SW-1:0] placed;
    logic [SW-1:0] frame_val;
    logic [31:0]   val32;
    logic [12:0]   dev_mask;
    logic [1:0]    status;
    logic          clr;
    logic          err;
    logic [CW-1:0] dur_c;
    logic          hit_hdr, hit_spc, hit_one, hit_zero, hit_trailer;

    function automatic logic in_win(input logic [CW-1:0] d, input sirc_win_t w);
        return (d >= CW'(w.lo)) && (d <= CW'(w.hi));
    endfunction

    always_comb
    begin
        unique case (cfg.variant)
            VAR_12:
            begin
                frame_len = LEN_12;
                dev_mask  = DEV_MASK_12;
            end
            VAR_15:
            begin
                frame_len = LEN_15;
                dev_mask  = DEV_MASK_15;
            end
            default:
            begin
                frame_len = LEN_20;
                dev_mask  = DEV_MASK_20;
            end
        endcase
    end

    assign dur_c       = CW'(duration);
    assign hit_hdr     = in_win(dur_c, cfg.hdr_mark);
    assign hit_spc     = in_win(dur_c, cfg.bit_space);
    assign hit_one     = in_win(dur_c, cfg.one_mark);
    assign hit_zero    = in_win(dur_c, cfg.zero_mark);
    assign hit_trailer = TW'(duration) >= TW'(cfg.trailer_min);

    assign len_ext   = {1'b0, frame_len};
    assign count_inc = {1'b0, count_reg} + 1'b1;
    // shift value with the pending bit dropped in at the current position
    assign placed    = shift_reg | (SW'(pending_reg) << count_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        pending_next = pending_reg;
        status       = ST_NONE;
        frame_val    = '0;
        clr          = 1'b0;
        err          = 1'b0;

        if (mode == MODE_TIMEOUT)
        begin
            clr = 1'b1;
            if (phase_reg == PH_BIT_SPACE && count_inc == len_ext)
            begin
                status    = ST_FRAME;
                frame_val = placed;
            end
            else if (count_reg == frame_len)
            begin
                status    = ST_FRAME;
                frame_val = shift_reg;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (mode == MODE_MARK && hit_hdr)
                    begin
                        phase_next   = PH_HDR_SPACE;
                        count_next   = '0;
                        shift_next   = '0;
                        pending_next = 1'b0;
                    end
                end
                PH_HDR_SPACE:
                begin
                    if (mode == MODE_SPACE && hit_spc)
                        phase_next = PH_BIT_MARK;
                    else
                        err = 1'b1;
                end
                PH_BIT_MARK:
                begin
                    if (mode == MODE_MARK && hit_one)
                    begin
                        pending_next = 1'b1;
                        phase_next   = PH_BIT_SPACE;
                    end
                    else if (mode == MODE_MARK && hit_zero)
                    begin
                        pending_next = 1'b0;
                        phase_next   = PH_BIT_SPACE;
                    end
                    else
                        err = 1'b1;
                end
                PH_BIT_SPACE:
                begin
                    // count at the length after a frame with no trailer; past it only after a variant change
                    if (mode != MODE_SPACE || count_reg >= frame_len)
                        err = 1'b1;
                    else
                    begin
                        shift_next = placed;
                        count_next = count_inc[LW-1:0];
                        if (count_inc == len_ext)
                        begin
                            if (hit_trailer)
                            begin
                                status    = ST_FRAME;
                                frame_val = placed;
                                clr       = 1'b1;
                            end
                            else
                                phase_next = PH_BIT_MARK;
                        end
                        else if (hit_spc)
                            phase_next = PH_BIT_MARK;
                        else
                            err = 1'b1;
                    end
                end
            endcase
        end

        if (err)
            status = ST_ERROR;
        if (clr || err)
        begin
            phase_next   = PH_IDLE;
            count_next   = '0;
            shift_next   = '0;
            pending_next = 1'b0;
        end
    end

    assign val32 = 32'(frame_val);

    always_comb
    begin
        result_next.status      = status;
        result_next.command     = val32[6:0];
        result_next.device      = val32[19:7] & dev_mask;
        result_next.raw_value   = val32[19:0];
        result_next.variant_out = (status == ST_FRAME) ? cfg.variant : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            shift_reg   <= '0;
            pending_reg <= 1'b0;
            result_reg  <= '0;
        end
        else if (load_en)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            pending_reg <= pending_next;
            result_reg  <= result_next;
        end
    end

    assign result = result_reg;

    `SIRC_ASSERT_IMPLY(a_idle_is_clear, clk, rst_n, phase_reg == PH_IDLE, (count_reg == '0) && (shift_reg == '0) && !pending_reg, "idle phase with receive state left over")
    `SIRC_ASSERT_IMPLY(a_fields_zero, clk, rst_n, result_reg.status != ST_FRAME, (result_reg.raw_value == '0) && (result_reg.variant_out == 2'd0), "frame fields set without frame status")
    `SIRC_ASSERT_NEXT(a_timeout_clears, clk, rst_n, load_en && (mode == MODE_TIMEOUT), (phase_reg == PH_IDLE) && (result_reg.status != ST_ERROR), "timeout did not reset the decoder")

endmodule

// File: rtl/sirc_ir_pulse_decoder.sv
`timescale 1ns / 1ps
// Top level of the SIRC infrared pulse decoder.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | mode, duration
//  out     | out_valid / out_ready| status, command, device, raw_value, variant_out
//  cfg     | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One request per clock sustained while out_ready is high; a taken request waits in the input
// register until the result register loads from it; out_valid rises with that load.
// Reset clears the decode state and loads the register defaults at once; no sweep follows.
// While out_ready is low the result holds, one more request waits in the input register,
// then in_ready falls.
`include "sirc_ir_pulse_decoder_defines.svh"
module sirc_ir_pulse_decoder
    import sirc_pkg::*;
#(
    parameter int DURATION_BITS  = 24,
    parameter int MAX_FRAME_BITS = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               mode,
    input  logic [DURATION_BITS-1:0] duration,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic [6:0]               command,
    output logic [12:0]              device,
    output logic [19:0]              raw_value,
    output logic [1:0]               variant_out
);

    sirc_cfg_t    cfg;
    sirc_result_t result;

    logic                     s1_valid_reg;
    logic [1:0]               mode_reg;
    logic [DURATION_BITS-1:0] dur_reg;
    logic                     out_valid_reg;
    logic                     s2_ready;
    logic                     load;
    logic                     in_take;

    sirc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sirc_core #(
        .DURATION_BITS  (DURATION_BITS),
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .load_en  (load),
        .mode     (mode_reg),
        .duration (dur_reg),
        .result   (result)
    );

    assign s2_ready = !out_valid_reg || out_ready;
    assign load     = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (load)
                s1_valid_reg <= 1'b0;

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            dur_reg  <= duration;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result.status;
    assign command     = result.command;
    assign device      = result.device;
    assign raw_value   = result.raw_value;
    assign variant_out = result.variant_out;

    `SIRC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, s1_valid_reg && out_valid_reg && !out_ready, "input stalled without a full pipe")
    `SIRC_ASSERT_NEXT(a_held_request, clk, rst_n, s1_valid_reg && !s2_ready, s1_valid_reg, "waiting request dropped")
    `SIRC_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid_reg, "decoded request not presented")

endmodule
